// ===== hw/rtl/gda_pkg.sv =====
`timescale 1ns / 1ps

package gda_pkg;

    localparam int MAX_YEAR_DEF = 9999;

    // field widths
    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int OFF_W  = 23;
    localparam int DIFF_W = 23;

    // internal widths
    localparam int YR_W  = 17;   // year counts, covers every estimate from a 25 bit day number
    localparam int SER_W = 25;   // signed serial day numbers and sums with the offset
    localparam int DBY_W = 27;   // days in a count of whole years
    localparam int DOY_W = 9;    // day of year, 0 based

    localparam logic signed [SER_W-1:0] DIFF_MAX = SER_W'((1 << (DIFF_W - 1)) - 1);
    localparam logic signed [SER_W-1:0] DIFF_MIN = -DIFF_MAX - SER_W'(1);

    // floor(k / 100) as multiply by reciprocal, exact for k below 2**17
    localparam logic [17:0] RECIP100    = 18'd167773;
    localparam int          RECIP100_SH = 24;

    // years from day number: floor(2**33 / 365.2425), rounded down
    localparam int             YR_SH    = 33;
    localparam logic [24:0]    YR_RECIP = 25'((64'd1 << YR_SH) * 64'd400 / 64'd146097);

    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    localparam logic [DOY_W-1:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
        9'd304, 9'd334
    };

    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic                     inv_a;
        logic                     inv_b;
        logic                     oor;
    } t_carry;

    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic [DAY_W-1:0]         day;
        logic [MON_W-1:0]         month;
        logic [YEAR_W-1:0]        year;
        logic                     inv_a;
        logic                     inv_b;
        logic                     oor;
    } t_result;

    function automatic logic [YR_W-1:0] div100(input logic [YR_W-1:0] k);
        logic [YR_W+17:0] p;
        p = (YR_W+18)'(k) * (YR_W+18)'(RECIP100);
        return YR_W'(p >> RECIP100_SH);
    endfunction

    // days in the first k years of the calendar
    function automatic logic [DBY_W-1:0] days_in_years(input logic [YR_W-1:0] k);
        logic [YR_W-1:0] q;
        q = div100(k);
        return DBY_W'(k) * DBY_W'(365) + DBY_W'(k >> 2) - DBY_W'(q) + DBY_W'(q >> 2);
    endfunction

    function automatic logic is_leap(input logic [YR_W-1:0] y);
        logic [YR_W-1:0] q;
        logic [YR_W-1:0] rem;
        q   = div100(y);
        rem = y - YR_W'(q * YR_W'(100));
        // divisible by 100 and by 16 is divisible by 400
        return (y[1:0] == 2'b00) && ((rem != '0) || (y[3:0] == 4'b0000));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        len = '0;
        if (m >= MON_JAN && m <= MON_DEC)
            len = MONTH_LEN[m - MON_JAN];
        if (m == MON_FEB && leap)
            len = DAY_W'(29);
        return len;
    endfunction

    // days of the year before the first of month m
    function automatic logic [DOY_W-1:0] month_first(input logic [MON_W-1:0] m,
                                                     input logic leap);
        logic [DOY_W-1:0] s;
        s = '0;
        if (m >= MON_JAN && m <= MON_DEC)
            s = MONTH_START[m - MON_JAN];
        if (m > MON_FEB && m <= MON_DEC && leap)
            s = s + DOY_W'(1);
        return s;
    endfunction

endpackage

// ===== hw/rtl/gregorian_date_arithmetic_top.sv =====
`timescale 1ns / 1ps
// throughput: one request per cycle through seven register stages (input, date to
// serial, offset add, year estimate multiply, year correction, day of year, month lookup)
// each stage holds its item only while the one after it is full and stalled
// reset clears the stage valid bits only; no request in flight survives it
module gregorian_date_arithmetic_top #(
    parameter int MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // day_a, month_a, year_a, day_b, month_b, year_b, day_offset, zero fill
    input  logic [71:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // day_difference, new_day, new_month, new_year, first_invalid, second_invalid,
    // out_of_range, zero fill
    output logic [55:0] o_m_axis_tdata
);

    localparam int SW = gda_pkg::SER_W;

    // serial of 31 december of the last year
    localparam int LP_HI = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;
    localparam logic signed [SW:0] LP_HI_S = (SW+1)'(LP_HI);

    typedef struct packed {
        logic signed [gda_pkg::OFF_W-1:0] off;
        logic [gda_pkg::YEAR_W-1:0]       year_b;
        logic [gda_pkg::MON_W-1:0]        month_b;
        logic [gda_pkg::DAY_W-1:0]        day_b;
        logic [gda_pkg::YEAR_W-1:0]       year_a;
        logic [gda_pkg::MON_W-1:0]        month_a;
        logic [gda_pkg::DAY_W-1:0]        day_a;
    } t_req;

    logic load_s1, load_s2, load_s3;
    logic fs_ready;

    logic                              r_s1_v, r_s2_v, r_s3_v;
    t_req                              r_s1, n_s1;
    logic signed [SW-1:0]              r_s2_sa, r_s2_sb;
    logic                              r_s2_ia, r_s2_ib;
    logic signed [gda_pkg::OFF_W-1:0]  r_s2_off;
    logic [SW-1:0]                     r_s3_n, n_s3_n;
    gda_pkg::t_carry                   r_s3_carry, n_s3_carry;

    logic signed [SW-1:0]              ser_a, ser_b;
    logic                              inv_a, inv_b;
    logic signed [SW-1:0]              diff, shifted;
    logic signed [SW:0]                shifted_x;

    gda_pkg::t_result                  res;

    assign n_s1 = t_req'(i_s_axis_tdata[68:0]);

    assign load_s3         = !r_s3_v || fs_ready;
    assign load_s2         = !r_s2_v || load_s3;
    assign load_s1         = !r_s1_v || load_s2;
    assign o_s_axis_tready = load_s1;

    gda_to_serial u_ser_a (
        .i_day     (r_s1.day_a),
        .i_month   (r_s1.month_a),
        .i_year    (r_s1.year_a),
        .o_serial  (ser_a),
        .o_invalid (inv_a)
    );

    gda_to_serial u_ser_b (
        .i_day     (r_s1.day_b),
        .i_month   (r_s1.month_b),
        .i_year    (r_s1.year_b),
        .o_serial  (ser_b),
        .o_invalid (inv_b)
    );

    always_comb begin
        diff      = r_s2_sa - r_s2_sb;
        shifted   = r_s2_sa + $signed({{(SW - gda_pkg::OFF_W){r_s2_off[gda_pkg::OFF_W-1]}},
                                       r_s2_off});
        shifted_x = $signed({shifted[SW-1], shifted});

        n_s3_carry.inv_a = r_s2_ia;
        n_s3_carry.inv_b = r_s2_ib;
        if (r_s2_ia || r_s2_ib) begin
            n_s3_carry.diff = '0;
        end else if (diff > gda_pkg::DIFF_MAX) begin
            n_s3_carry.diff = gda_pkg::DIFF_W'(gda_pkg::DIFF_MAX);
        end else if (diff < gda_pkg::DIFF_MIN) begin
            n_s3_carry.diff = gda_pkg::DIFF_W'(gda_pkg::DIFF_MIN);
        end else begin
            n_s3_carry.diff = gda_pkg::DIFF_W'(diff);
        end
        n_s3_carry.oor = !r_s2_ia && ((shifted < SW'(1)) || (shifted_x > LP_HI_S));
        // zero based day count for the date split
        n_s3_n = SW'(shifted - SW'(1));
    end

    gda_from_serial u_from_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_v),
        .o_ready (fs_ready),
        .i_n     (r_s3_n),
        .i_carry (r_s3_carry),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res)
    );

    assign o_m_axis_tdata = {7'b0, res.oor, res.inv_b, res.inv_a, res.year, res.month,
                             res.day, res.diff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (load_s1) r_s1_v <= i_s_axis_tvalid;
            if (load_s2) r_s2_v <= r_s1_v;
            if (load_s3) r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_s1) begin
            r_s1 <= n_s1;
        end
        if (load_s2) begin
            r_s2_sa  <= ser_a;
            r_s2_sb  <= ser_b;
            r_s2_ia  <= inv_a;
            r_s2_ib  <= inv_b;
            r_s2_off <= r_s1.off;
        end
        if (load_s3) begin
            r_s3_n     <= n_s3_n;
            r_s3_carry <= n_s3_carry;
        end
    end

endmodule

// ===== hw/rtl/gda_to_serial.sv =====
`timescale 1ns / 1ps

module gda_to_serial (
    input  logic [gda_pkg::DAY_W-1:0]         i_day,
    input  logic [gda_pkg::MON_W-1:0]         i_month,
    input  logic [gda_pkg::YEAR_W-1:0]        i_year,
    output logic signed [gda_pkg::SER_W-1:0]  o_serial,
    output logic                              o_invalid
);

    logic [gda_pkg::YR_W-1:0]        year_ext;
    logic                            leap;
    logic [gda_pkg::DAY_W-1:0]       dim;
    logic [gda_pkg::DBY_W-1:0]       dby;
    logic signed [gda_pkg::SER_W-1:0] base;

    assign year_ext  = gda_pkg::YR_W'(i_year);
    assign leap      = gda_pkg::is_leap(year_ext);
    // a bad month gives zero days, so any day fails
    assign dim       = gda_pkg::month_days(i_month, leap);
    assign o_invalid = (i_day == '0) || (i_day > dim);
    assign dby       = gda_pkg::days_in_years(year_ext - gda_pkg::YR_W'(1));

    always_comb begin
        // year zero is leap and starts one leap year before year one
        if (i_year == '0) begin
            base = -gda_pkg::SER_W'(366);
        end else begin
            base = $signed(gda_pkg::SER_W'(dby));
        end
        o_serial = base
                 + $signed(gda_pkg::SER_W'(gda_pkg::month_first(i_month, leap)))
                 + $signed(gda_pkg::SER_W'(i_day));
    end

endmodule

// ===== hw/rtl/gda_from_serial.sv =====
`timescale 1ns / 1ps

module gda_from_serial (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [gda_pkg::SER_W-1:0]     i_n,
    input  gda_pkg::t_carry               i_carry,
    output logic                          o_valid,
    input  logic                          i_ready,
    output gda_pkg::t_result              o_res
);

    localparam int PW = gda_pkg::SER_W + 25;

    logic load_a, load_b, load_c, load_o;

    logic                          r_a_v, r_b_v, r_c_v, r_o_v;
    logic [gda_pkg::YR_W-1:0]      r_a_e, n_a_e;
    logic [gda_pkg::SER_W-1:0]     r_a_n, r_b_n;
    gda_pkg::t_carry               r_a_carry, r_b_carry, r_c_carry;
    logic [gda_pkg::YR_W-1:0]      r_b_y0, n_b_y0;
    logic [gda_pkg::DOY_W-1:0]     r_c_doy, n_c_doy;
    logic [gda_pkg::YR_W-1:0]      r_c_year, n_c_year;
    logic                          r_c_leap, n_c_leap;
    gda_pkg::t_result              r_o, n_o;

    logic [PW-1:0]                 prod;
    logic [gda_pkg::YR_W-1:0]      e_raw;
    logic [gda_pkg::MON_W-1:0]     mon;

    assign load_o  = !r_o_v || i_ready;
    assign load_c  = !r_c_v || load_o;
    assign load_b  = !r_b_v || load_c;
    assign load_a  = !r_a_v || load_b;
    assign o_ready = load_a;
    assign o_valid = r_o_v;
    assign o_res   = r_o;

    // year estimate, at most three below the true count of whole years
    always_comb begin
        prod  = PW'(i_n) * PW'(gda_pkg::YR_RECIP);
        e_raw = gda_pkg::YR_W'(prod >> gda_pkg::YR_SH);
        n_a_e = (e_raw == '0) ? '0 : e_raw - gda_pkg::YR_W'(1);
    end

    always_comb begin
        n_b_y0 = r_a_e;
        for (int j = 1; j <= 3; j++) begin
            if (gda_pkg::DBY_W'(r_a_n) >=
                gda_pkg::days_in_years(r_a_e + gda_pkg::YR_W'(j))) begin
                n_b_y0 = n_b_y0 + gda_pkg::YR_W'(1);
            end
        end
    end

    always_comb begin
        n_c_doy  = gda_pkg::DOY_W'(gda_pkg::DBY_W'(r_b_n) - gda_pkg::days_in_years(r_b_y0));
        n_c_year = r_b_y0 + gda_pkg::YR_W'(1);
        n_c_leap = gda_pkg::is_leap(n_c_year);
    end

    always_comb begin
        mon = gda_pkg::MON_JAN;
        for (int m = int'(gda_pkg::MON_FEB); m <= int'(gda_pkg::MON_DEC); m++) begin
            if (r_c_doy >= gda_pkg::month_first(gda_pkg::MON_W'(m), r_c_leap)) begin
                mon = gda_pkg::MON_W'(m);
            end
        end
        n_o.diff  = r_c_carry.diff;
        n_o.inv_a = r_c_carry.inv_a;
        n_o.inv_b = r_c_carry.inv_b;
        n_o.oor   = r_c_carry.oor;
        if (r_c_carry.inv_a || r_c_carry.oor) begin
            n_o.day   = '0;
            n_o.month = '0;
            n_o.year  = '0;
        end else begin
            n_o.day   = gda_pkg::DAY_W'(r_c_doy - gda_pkg::month_first(mon, r_c_leap)
                                        + gda_pkg::DOY_W'(1));
            n_o.month = mon;
            n_o.year  = gda_pkg::YEAR_W'(r_c_year);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (load_a) r_a_v <= i_valid;
            if (load_b) r_b_v <= r_a_v;
            if (load_c) r_c_v <= r_b_v;
            if (load_o) r_o_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_a) begin
            r_a_e     <= n_a_e;
            r_a_n     <= i_n;
            r_a_carry <= i_carry;
        end
        if (load_b) begin
            r_b_y0    <= n_b_y0;
            r_b_n     <= r_a_n;
            r_b_carry <= r_a_carry;
        end
        if (load_c) begin
            r_c_doy   <= n_c_doy;
            r_c_year  <= n_c_year;
            r_c_leap  <= n_c_leap;
            r_c_carry <= r_b_carry;
        end
        if (load_o) begin
            r_o <= n_o;
        end
    end

endmodule
